// ----- rtl/csh_pkg.sv -----
package csh_pkg;

    // Fixed field widths
    localparam int PIX_W      = 8;
    localparam int NUM_BINS   = 256;
    localparam int BIN_AW     = 8;
    localparam int FACTOR_W   = 9;
    localparam int OUT_CNT_W  = 24;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    // Result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 4'd1;

    // Command codes
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;

    // Window and factor as seen by the datapath
    typedef struct packed {
        t_pix                lower;
        t_pix                upper;
        logic [FACTOR_W-1:0] factor;
        logic                busy;
    } t_stretch_cfg;

    // One queued result word
    typedef struct packed {
        t_pix                 gray;
        logic [OUT_CNT_W-1:0] count;
    } t_result;

endpackage

// ----- rtl/csh_if.sv -----
interface csh_in_if;
    logic       valid;
    logic       ready;
    logic       cmd;
    logic [7:0] gray_in;
    logic [7:0] bin_index;

    modport source (output valid, cmd, gray_in, bin_index, input ready);
    modport sink   (input valid, cmd, gray_in, bin_index, output ready);
endinterface

interface csh_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  gray_out;
    logic [23:0] bin_count;

    modport source (output valid, gray_out, bin_count, input ready);
    modport sink   (input valid, gray_out, bin_count, output ready);
endinterface

interface csh_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/csh_factor.sv -----
module csh_factor
    import csh_pkg::*;
#(
    parameter int SCALE_MAX = 255
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    csh_cfg_if.sink      i_cfg,
    output t_stretch_cfg o_cfg
);

    localparam logic [FACTOR_W-1:0] DIVIDEND     = FACTOR_W'(SCALE_MAX);
    localparam logic [FACTOR_W-1:0] RESET_FACTOR = FACTOR_W'(SCALE_MAX / 255);
    localparam logic [3:0]          LAST_STEP    = 4'(FACTOR_W - 1);

    t_pix                r_lower, n_lower;
    t_pix                r_upper, n_upper;
    logic [FACTOR_W-1:0] r_factor, n_factor;
    logic                r_busy, n_busy;
    logic [3:0]          r_step, n_step;
    logic [FACTOR_W-1:0] r_rem, n_rem;
    logic [FACTOR_W-1:0] r_quo, n_quo;
    t_pix                r_div, n_div;

    logic                wr;
    logic [FACTOR_W-1:0] shifted;
    logic                ge;

    assign i_cfg.ready = 1'b1;
    assign wr = i_cfg.valid && (i_cfg.index == REG_LOWER || i_cfg.index == REG_UPPER);

    // One quotient bit per cycle, restoring division
    assign shifted = {r_rem[FACTOR_W-2:0], r_quo[FACTOR_W-1]};
    assign ge      = shifted >= {1'b0, r_div};

    always_comb begin
        n_lower  = r_lower;
        n_upper  = r_upper;
        n_factor = r_factor;
        n_busy   = r_busy;
        n_step   = r_step;
        n_rem    = r_rem;
        n_quo    = r_quo;
        n_div    = r_div;
        if (wr) begin
            if (i_cfg.index == REG_LOWER) begin
                n_lower = i_cfg.data;
            end else begin
                n_upper = i_cfg.data;
            end
            // Start a new division, or take the empty window at once
            if (n_upper > n_lower) begin
                n_busy = 1'b1;
                n_step = '0;
                n_rem  = '0;
                n_quo  = DIVIDEND;
                n_div  = n_upper - n_lower;
            end else begin
                n_busy   = 1'b0;
                n_factor = '0;
            end
        end else if (r_busy) begin
            n_rem  = ge ? (shifted - {1'b0, r_div}) : shifted;
            n_quo  = {r_quo[FACTOR_W-2:0], ge};
            n_step = r_step + 4'd1;
            if (r_step == LAST_STEP) begin
                n_factor = n_quo;
                n_busy   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower  <= '0;
            r_upper  <= '1;
            r_factor <= RESET_FACTOR;
            r_busy   <= 1'b0;
            r_step   <= '0;
        end else begin
            r_lower  <= n_lower;
            r_upper  <= n_upper;
            r_factor <= n_factor;
            r_busy   <= n_busy;
            r_step   <= n_step;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_div <= n_div;
    end

    assign o_cfg.lower  = r_lower;
    assign o_cfg.upper  = r_upper;
    assign o_cfg.factor = r_factor;
    assign o_cfg.busy   = r_busy;

endmodule

// ----- rtl/csh_hist.sv -----
module csh_hist
    import csh_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_stretch_cfg i_cfg,
    csh_in_if.sink       i_pix,
    csh_out_if.source    o_res
);

    typedef logic [COUNT_BITS-1:0] t_count;

    // Histogram storage and per-bin valid bits
    t_count               r_mem [NUM_BINS];
    logic [NUM_BINS-1:0]  r_vld;

    // Stage 1: read in flight
    logic                 r_s1_vld;
    logic                 r_s1_cmd;
    logic [BIN_AW-1:0]    r_s1_addr;
    t_pix                 r_s1_gray;
    t_count               r_rd_data;
    logic                 r_rd_hit;

    // Last write, for forwarding
    logic                 r_fw_vld;
    logic [BIN_AW-1:0]    r_fw_addr;
    t_count               r_fw_data;

    // Result queue
    t_result              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wp;
    logic [FIFO_AW-1:0]   r_rp;
    logic [FIFO_AW:0]     r_cnt;

    logic                 accept;
    logic                 pop;
    logic [FIFO_AW:0]     used;
    logic                 in_win;
    t_pix                 diff;
    logic [PIX_W+FACTOR_W-1:0] prod;
    t_pix                 mapped;
    logic [BIN_AW-1:0]    addr;
    logic                 fwd;
    t_count               cur;
    t_count               n_wdata;
    logic [31:0]          cur_ext;
    t_result              push_word;

    // Accept while the factor is settled and the queue has room for all in flight
    assign used        = r_cnt + (FIFO_AW+1)'(r_s1_vld);
    assign i_pix.ready = !i_cfg.busy && (used < (FIFO_AW+1)'(FIFO_DEPTH));
    assign accept      = i_pix.valid && i_pix.ready;

    // Stretch the incoming pixel
    assign in_win = (i_pix.gray_in > i_cfg.lower) && (i_pix.gray_in <= i_cfg.upper);
    assign diff   = i_pix.gray_in - i_cfg.lower;
    assign prod   = (PIX_W+FACTOR_W)'(diff) * (PIX_W+FACTOR_W)'(i_cfg.factor);
    always_comb begin
        if (!in_win) begin
            mapped = '0;
        end else if (prod > (PIX_W+FACTOR_W)'(255)) begin
            mapped = '1;
        end else begin
            mapped = prod[PIX_W-1:0];
        end
    end
    assign addr = (i_pix.cmd == CMD_READ) ? i_pix.bin_index : mapped;

    // Issue the bin read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
        if (accept) begin
            r_s1_cmd  <= i_pix.cmd;
            r_s1_addr <= addr;
            r_s1_gray <= mapped;
            r_rd_data <= r_mem[addr];
            r_rd_hit  <= r_vld[addr];
        end
    end

    // Modify: forward the write that landed on the edge of this read
    assign fwd = r_fw_vld && (r_fw_addr == r_s1_addr);
    always_comb begin
        if (fwd) begin
            cur = r_fw_data;
        end else if (r_rd_hit) begin
            cur = r_rd_data;
        end else begin
            cur = '0;
        end
    end
    always_comb begin
        if (r_s1_cmd == CMD_READ) begin
            n_wdata = '0;
        end else if (cur == '1) begin
            n_wdata = cur;
        end else begin
            n_wdata = cur + t_count'(1);
        end
    end
    assign cur_ext = 32'(cur);

    // Write back
    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_mem[r_s1_addr] <= n_wdata;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_fw_vld <= 1'b0;
        end else begin
            r_fw_vld <= r_s1_vld;
            if (r_s1_vld) begin
                r_vld[r_s1_addr] <= 1'b1;
            end
        end
        r_fw_addr <= r_s1_addr;
        r_fw_data <= n_wdata;
    end

    // Push the result word
    always_comb begin
        if (r_s1_cmd == CMD_READ) begin
            push_word.gray  = '0;
            push_word.count = cur_ext[OUT_CNT_W-1:0];
        end else begin
            push_word.gray  = r_s1_gray;
            push_word.count = '0;
        end
    end

    assign pop = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (r_s1_vld) begin
                r_wp <= r_wp + FIFO_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + FIFO_AW'(1);
            end
            r_cnt <= r_cnt + (FIFO_AW+1)'(r_s1_vld) - (FIFO_AW+1)'(pop);
        end
        if (r_s1_vld) begin
            r_fifo[r_wp] <= push_word;
        end
    end

    assign o_res.valid     = r_cnt != '0;
    assign o_res.gray_out  = r_fifo[r_rp].gray;
    assign o_res.bin_count = r_fifo[r_rp].count;

    // Queue never overfills
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (FIFO_AW+1)'(FIFO_DEPTH))
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !pop) |-> (r_cnt < (FIFO_AW+1)'(FIFO_DEPTH)))
        else $error("result queue overflow");

    // No pixel enters while the factor is being recomputed
    a_busy_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> !i_cfg.busy)
        else $error("word accepted during factor update");

    // A read command leaves its bin cleared
    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && r_s1_cmd == CMD_READ) |=> (r_fw_vld && r_fw_data == '0))
        else $error("read command did not clear its bin");

endmodule

// ----- rtl/contrast_stretch_histogram.sv -----
// Linear contrast stretch of 8-bit gray pixels with a 256-bin histogram.
// Channels: i_pix carries one word per pixel (cmd 0) or bin read (cmd 1);
// o_res returns exactly one word per accepted input word, in order; i_cfg
// writes lower_level (index 0) or upper_level (index 1), other indexes drop.
// Path: an accepted word is registered in the read stage, then written
// into the result queue, from which o_res presents it.
// Throughput: one word per cycle while i_pix.ready is high. The bins sit
// in one memory with a registered read; a read-modify-write of the same bin
// on consecutive words is served by forwarding the last write.
// A register write recomputes the factor with a one-bit-per-cycle divider:
// i_pix.ready stays low after a write to a non-empty window until the division is done.
// Reset: window 0..255, factor SCALE_MAX/255, all bins read as zero at once
// through per-bin valid bits, so no clearing pass is needed.
// Stall: results wait in a four-word queue; while the receiver holds off,
// input is taken until the queue and the word in flight fill it.
module contrast_stretch_histogram
    import csh_pkg::*;
#(
    parameter int SCALE_MAX  = 255,
    parameter int COUNT_BITS = 24
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    csh_cfg_if.sink   i_cfg,
    csh_in_if.sink    i_pix,
    csh_out_if.source o_res
);

    t_stretch_cfg stretch_cfg;

    // Window registers and factor divider
    csh_factor #(
        .SCALE_MAX (SCALE_MAX)
    ) u_factor (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (stretch_cfg)
    );

    // Stretch, histogram memory and result queue
    csh_hist #(
        .COUNT_BITS (COUNT_BITS)
    ) u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (stretch_cfg),
        .i_pix   (i_pix),
        .o_res   (o_res)
    );

endmodule
